// ===== hdl/dq_pkg.sv =====
// Shared command codes, status codes and stream widths for the double-ended queue.
package dq_pkg;

	// Command field of an input request
	localparam int unsigned CMD_W = 4;
	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_PUSH_BACK   = 4'd0;
	localparam cmd_t CMD_PUSH_FRONT  = 4'd1;
	localparam cmd_t CMD_POP_BACK    = 4'd2;
	localparam cmd_t CMD_POP_FRONT   = 4'd3;
	localparam cmd_t CMD_PEEK_BACK   = 4'd4;
	localparam cmd_t CMD_PEEK_FRONT  = 4'd5;
	localparam cmd_t CMD_WRITE_BACK  = 4'd6;
	localparam cmd_t CMD_WRITE_FRONT = 4'd7;
	localparam cmd_t CMD_CLEAR       = 4'd8;

	// Result status
	localparam int unsigned ST_W = 2;
	typedef logic [ST_W-1:0] status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// Field widths on the stream ports
	localparam int unsigned DIN_W  = 32;
	localparam int unsigned DOUT_W = 32;
	localparam int unsigned CNT_W  = 9;

	localparam int unsigned IN_RAW_W     = CMD_W + DIN_W;
	localparam int unsigned IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
	localparam int unsigned OUT_RAW_W    = DOUT_W + ST_W + CNT_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

	typedef logic [DIN_W-1:0]  din_t;
	typedef logic [DOUT_W-1:0] dout_t;
	typedef logic [CNT_W-1:0]  cnt_t;

endpackage

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue over a ring buffer RAM, one command per cycle.
// The request is registered in input stage s1; its result is registered in result stage s2 and presented from there.
// Throughput: one command per cycle; at most one RAM access (read or write) per command.
// Back pressure on the result side holds both stages; input is still taken while s1 is free.
// Reset (arst_n low, async): queue empty, both ring indices zero, no results pending.
// Slot contents are not cleared; only held elements are ever read.
module double_ended_queue #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [3:0] command, [35:4] data_in, [39:36] zero
	input  logic [dq_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] data_out, [33:32] status, [42:34] count, [47:43] zero
	output logic [dq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);

	// input stage
	logic                 valid_s1;
	dq_pkg::cmd_t         cmd_s1;
	dq_pkg::din_t         din_s1;

	// result stage
	logic                 valid_s2;
	dq_pkg::status_t      status_s2;
	dq_pkg::cnt_t         count_s2;
	logic                 rd_s2;

	// ring state
	logic [AW-1:0]        front_q;
	logic [AW-1:0]        back_q;
	logic [FW-1:0]        fill_q;

	logic                 advance;
	logic                 full;
	logic                 empty;
	logic [AW-1:0]        front_prev;
	logic [AW-1:0]        front_next;
	logic [AW-1:0]        back_prev;
	logic [AW-1:0]        back_next;
	logic [AW-1:0]        pos;

	logic [AW-1:0]        front_n;
	logic [AW-1:0]        back_n;
	logic [FW-1:0]        fill_n;
	dq_pkg::status_t      status_n;
	logic                 wr_n;
	logic                 rd_n;
	logic [AW-1:0]        addr_n;

	logic [63:0]          din_ext;
	logic [WIDTH-1:0]     ram_wdata;
	logic [WIDTH-1:0]     ram_rdata;
	logic [63:0]          rdata_ext;
	logic [31:0]          fill_ext;
	dq_pkg::dout_t        dout;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tdata[dq_pkg::CMD_W-1:0];
			din_s1 <= s_tdata[dq_pkg::CMD_W +: dq_pkg::DIN_W];
		end
	end

	assign full  = (fill_q == FULL_CNT);
	assign empty = (fill_q == '0);

	assign front_prev = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_next = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
	assign back_prev  = (back_q == '0) ? LAST_IDX : back_q - AW'(1);
	assign back_next  = (back_q == LAST_IDX) ? '0 : back_q + AW'(1);

	// among the access codes, odd codes act on the front, even codes on the back
	assign pos = cmd_s1[0] ? front_q : back_prev;

	always_comb begin
		front_n  = front_q;
		back_n   = back_q;
		fill_n   = fill_q;
		status_n = dq_pkg::ST_OK;
		wr_n     = 1'b0;
		rd_n     = 1'b0;
		addr_n   = pos;
		case (cmd_s1)
			dq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_n = dq_pkg::ST_FULL;
				end else begin
					wr_n   = 1'b1;
					addr_n = back_q;
					back_n = back_next;
					fill_n = fill_q + FW'(1);
				end
			end
			dq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_n = dq_pkg::ST_FULL;
				end else begin
					wr_n    = 1'b1;
					addr_n  = front_prev;
					front_n = front_prev;
					fill_n  = fill_q + FW'(1);
				end
			end
			dq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_n = dq_pkg::ST_EMPTY;
				end else begin
					rd_n   = 1'b1;
					back_n = back_prev;
					fill_n = fill_q - FW'(1);
				end
			end
			dq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_n = dq_pkg::ST_EMPTY;
				end else begin
					rd_n    = 1'b1;
					front_n = front_next;
					fill_n  = fill_q - FW'(1);
				end
			end
			dq_pkg::CMD_PEEK_BACK, dq_pkg::CMD_PEEK_FRONT: begin
				if (empty) begin
					status_n = dq_pkg::ST_EMPTY;
				end else begin
					rd_n = 1'b1;
				end
			end
			dq_pkg::CMD_WRITE_BACK, dq_pkg::CMD_WRITE_FRONT: begin
				if (empty) begin
					status_n = dq_pkg::ST_EMPTY;
				end else begin
					wr_n = 1'b1;
				end
			end
			dq_pkg::CMD_CLEAR: begin
				front_n = '0;
				back_n  = '0;
				fill_n  = '0;
			end
			default: begin
				// unused codes: no effect
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			back_q   <= '0;
			fill_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				front_q <= front_n;
				back_q  <= back_n;
				fill_q  <= fill_n;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign fill_ext = 32'(fill_n);

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_n;
			count_s2  <= fill_ext[dq_pkg::CNT_W-1:0];
			rd_s2     <= rd_n;
		end
	end

	assign din_ext   = 64'(din_s1);
	assign ram_wdata = din_ext[WIDTH-1:0];

	dq_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (advance && wr_n),
		.waddr(addr_n),
		.wdata(ram_wdata),
		.re   (advance && rd_n),
		.raddr(addr_n),
		.rdata(ram_rdata)
	);

	// read data register only moves on a read, so it holds while the result stalls
	assign rdata_ext = 64'(ram_rdata);
	assign dout      = rd_s2 ? rdata_ext[dq_pkg::DOUT_W-1:0] : '0;

	assign m_tvalid = valid_s2;
	assign m_tdata  = {
		(dq_pkg::OUT_TDATA_W - dq_pkg::OUT_RAW_W)'(0),
		count_s2,
		status_s2,
		dout
	};

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count exceeds ring depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == dq_pkg::ST_FULL |-> count_s2 == FULL_CNT[dq_pkg::CNT_W-1:0])
		else $error("full status reported with a count below depth");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == dq_pkg::ST_EMPTY |-> !rd_s2 && count_s2 == '0)
		else $error("empty status with a read or a nonzero count");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(fill_q) && $stable(front_q) && $stable(back_q))
		else $error("ring state moved without a command");
`endif

endmodule

// ===== hdl/dq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module dq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
